### rtl/sdta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_pkg
// Shared types and constants for the signed decimal to ASCII converter.
// ----------------------------------------------------------------------------
package sdta_pkg;

   localparam int VALUE_BITS = 32;
   // decimal digits needed for 2^VALUE_BITS: ceil(VALUE_BITS * log10(2))
   localparam int DIGITS     = (VALUE_BITS * 30103 + 99999) / 100000;
   localparam int COUNT_BITS = $clog2(VALUE_BITS);
   localparam int LEFT_BITS  = $clog2(DIGITS + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic clear;
      logic convert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

### rtl/sdta_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_cell
// One BCD digit of the conversion row: add-3 and shift during conversion,
// plain digit shift toward the top while the text is read out.
// ----------------------------------------------------------------------------
module sdta_cell import sdta_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          lower_bit,
   input  digit_type     lower_digit,
   output digit_type     digit,
   output logic          carry
);

   digit_type digit_ff;
   digit_type digit_in;
   digit_type adjusted;

   assign adjusted = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry    = adjusted[3];
   assign digit    = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.convert) begin
         digit_in = {adjusted[2:0], lower_bit};
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

### rtl/signed_decimal_to_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_to_ascii
// Prints one signed integer per word as decimal ASCII, one character a word.
// ----------------------------------------------------------------------------
// Input: req_value is taken when req_valid is high and req_stall is low.
// Output: one character per word on rsp_character, rsp_last marks the final
// character of a number. A word moves when rsp_valid is high and rsp_stall
// is low; a stalled word holds.
// Text: optional '-', then the digits without leading zeros; zero is "0".
// The most negative value prints its full magnitude.
// Sequence: after an accept the magnitude shifts bit by bit through a row of
// BCD digit cells, then a negative number loads a '-', leading zeros are
// dropped one per cycle (up to 9), one more step settles on the top digit,
// and then each digit is loaded in turn. The next number can be taken once
// the last character has been loaded.
// req_stall is high from the accept until the last character has been loaded
// into the output register.
// Reset clears the sequencer and the output valid; no number is in flight
// afterwards. Receiver stall holds only the sign and digit output steps.
// ----------------------------------------------------------------------------
module signed_decimal_to_ascii import sdta_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last
);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LEFT_BITS-1:0]  left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_character_ff, rsp_character_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type         ctrl;
   digit_type             digits [DIGITS];
   logic [DIGITS-1:0]     carries;
   digit_type             top_digit;
   logic [VALUE_BITS-1:0] value_bits;
   logic                  out_free;
   logic                  lead_zero;

   assign value_bits = $unsigned(req_value);
   assign top_digit  = digits[DIGITS-1];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign lead_zero  = (top_digit == 4'd0) && (left_ff > LEFT_BITS'(1));

   // cell 0 takes the magnitude MSB; each cell feeds the next one up
   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      logic      lower_bit;
      digit_type lower_digit;
      if (i == 0) begin : g_first
         assign lower_bit   = mag_ff[VALUE_BITS-1];
         assign lower_digit = '0;
      end else begin : g_rest
         assign lower_bit   = carries[i-1];
         assign lower_digit = digits[i-1];
      end
      sdta_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .lower_bit   (lower_bit),
         .lower_digit (lower_digit),
         .digit       (digits[i]),
         .carry       (carries[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (count_ff == COUNT_BITS'(VALUE_BITS - 1)) begin
               state_in = neg_ff ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!lead_zero) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && left_ff == LEFT_BITS'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      count_in         = count_ff;
      left_in          = left_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      ctrl             = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in     = value_bits[VALUE_BITS-1];
               mag_in     = value_bits[VALUE_BITS-1] ? (~value_bits + 1'b1) : value_bits;
               count_in   = '0;
               left_in    = LEFT_BITS'(DIGITS);
               ctrl.clear = 1'b1;
            end
         end
         ST_CONVERT: begin
            ctrl.convert = 1'b1;
            mag_in       = {mag_ff[VALUE_BITS-2:0], 1'b0};
            count_in     = count_ff + 1'b1;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_MINUS;
               rsp_last_in      = 1'b0;
            end
         end
         ST_SKIP: begin
            if (lead_zero) begin
               ctrl.shift = 1'b1;
               left_in    = left_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_ZERO + {4'b0000, top_digit};
               rsp_last_in      = (left_ff == LEFT_BITS'(1));
               ctrl.shift       = 1'b1;
               left_in          = left_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      count_ff         <= count_in;
      left_ff          <= left_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### rtl/sdta_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_checker
// Port-level checks for signed_decimal_to_ascii, bound to the top level.
// ----------------------------------------------------------------------------
module sdta_checker import sdta_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [7:0]                   rsp_character,
   input logic                         rsp_last
);

   // stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled output word changed");

   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS) ||
                    (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE))
      else $error("output character is not a sign or digit");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last");

   // busy from the accept on: one number at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a number is in progress");

endmodule

bind signed_decimal_to_ascii sdta_checker u_sdta_checker (.*);
